@@ hw/rtl/wb512_pkg.sv @@
// types, constants and microcode program for the well512 random generator
package wb512_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned IndexWidth = 4;
   localparam int unsigned PcWidth    = 4;
   localparam int unsigned CountWidth = 5;

   localparam logic [WordWidth-1:0]  TemperMask = 32'hDA442D24;
   localparam logic [IndexWidth-1:0] TapA       = 4'd13;
   localparam logic [IndexWidth-1:0] TapB       = 4'd9;
   localparam logic [IndexWidth-1:0] StepBack   = 4'd15;
   localparam logic [CountWidth-1:0] DivLast    = 5'd31;

   localparam logic FuncLoad     = 1'b0;
   localparam logic FuncGenerate = 1'b1;

   // program entry points
   localparam logic [PcWidth-1:0] PcGen     = 4'd0;
   localparam logic [PcWidth-1:0] PcEmitGen = 4'd7;
   localparam logic [PcWidth-1:0] PcEmitOff = 4'd8;
   localparam logic [PcWidth-1:0] PcLoad    = 4'd9;
   localparam logic [PcWidth-1:0] PcLast    = 4'd9;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_I,
      RD_I13,
      RD_I9,
      RD_I15
   } rd_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH_X,
      OP_MIX,
      OP_LATCH_Z,
      OP_FRESH,
      OP_FINAL,
      OP_DIV_STEP,
      OP_EMIT_GEN,
      OP_EMIT_OFF,
      OP_LOAD
   } op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_SKIP_IF_ZERO,
      SEQ_LOOP,
      SEQ_END
   } seq_type;

   typedef struct packed {
      rd_sel_type         rd_sel;
      op_type             op;
      seq_type            seq;
      logic [PcWidth-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic                  rd_en;
      logic [IndexWidth-1:0] rd_addr;
      logic                  wr_en;
      logic [IndexWidth-1:0] wr_addr;
      logic [WordWidth-1:0]  wr_data;
   } pool_req_type;

   function automatic ucode_type ucode_rom(input logic [PcWidth-1:0] pc);
      ucode_type cw;
      cw = '{rd_sel: RD_NONE, op: OP_NONE, seq: SEQ_END, target: PcGen};
      case (pc)
         4'd0: cw = '{rd_sel: RD_I,    op: OP_NONE,     seq: SEQ_NEXT, target: PcGen};
         4'd1: cw = '{rd_sel: RD_I13,  op: OP_LATCH_X,  seq: SEQ_NEXT, target: PcGen};
         4'd2: cw = '{rd_sel: RD_I9,   op: OP_MIX,      seq: SEQ_NEXT, target: PcGen};
         4'd3: cw = '{rd_sel: RD_NONE, op: OP_LATCH_Z,  seq: SEQ_NEXT, target: PcGen};
         4'd4: cw = '{rd_sel: RD_I15,  op: OP_FRESH,    seq: SEQ_NEXT, target: PcGen};
         4'd5: cw = '{rd_sel: RD_NONE, op: OP_FINAL,    seq: SEQ_SKIP_IF_ZERO,
                      target: PcEmitGen};
         4'd6: cw = '{rd_sel: RD_NONE, op: OP_DIV_STEP, seq: SEQ_LOOP, target: PcGen};
         4'd7: cw = '{rd_sel: RD_NONE, op: OP_EMIT_GEN, seq: SEQ_END,  target: PcGen};
         4'd8: cw = '{rd_sel: RD_NONE, op: OP_EMIT_OFF, seq: SEQ_END,  target: PcGen};
         4'd9: cw = '{rd_sel: RD_NONE, op: OP_LOAD,     seq: SEQ_END,  target: PcGen};
         default: cw = '{rd_sel: RD_NONE, op: OP_NONE, seq: SEQ_END, target: PcGen};
      endcase
      return cw;
   endfunction

endpackage

@@ hw/rtl/well512_random_generator.sv @@
// WELL512a generator top level: microcoded sequencer, pool and remainder loop
//
// An item is taken when start is high and busy is low; busy stays high until
// its program ends. A load item (func 0) runs one step and gives no result. A
// generate item runs six pool steps, then 32 shift-subtract steps of the
// remainder loop, then one emit step; the loop is skipped when the span
// wraps to zero. With the csr enable bit clear it runs only the emit step.
// The result is driven for one cycle with rsp_strobe in the cycle after the
// emit step; the receiver has no way to hold it off. The remainder loop sets
// the rate, one bit per cycle through a single 33-bit subtractor.
module well512_random_generator import wb512_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [31:0]        req_seed_word,
   input  logic signed [31:0] req_range_min,
   input  logic signed [31:0] req_range_max,
   input  logic               csr_we,
   input  logic               csr_wdata,
   output logic               rsp_strobe,
   output logic [31:0]        rsp_random_word,
   output logic signed [31:0] rsp_ranged_value,
   output logic               rsp_span_zero
);

   logic                  running_ff, running_in;
   logic [PcWidth-1:0]    pc_ff, pc_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic [IndexWidth-1:0] lp_ff, lp_in;
   logic                  enable_ff;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  strobe_ff, strobe_in;

   logic [WordWidth-1:0]  seed_ff, min_ff, span_ff;
   logic [WordWidth-1:0]  x_ff, x_in;
   logic [WordWidth-1:0]  mix_ff, mix_in;
   logic [WordWidth-1:0]  z_ff, z_in;
   logic [WordWidth-1:0]  tmp_ff, tmp_in;
   logic [WordWidth-1:0]  word_ff, word_in;
   logic [WordWidth-1:0]  rem_ff, rem_in;
   logic [WordWidth-1:0]  dq_ff, dq_in;
   logic [WordWidth-1:0]  out_word_ff, out_word_in;
   logic [WordWidth-1:0]  out_ranged_ff, out_ranged_in;
   logic                  out_zero_ff, out_zero_in;

   logic                  accept;
   logic                  span_is_zero;
   ucode_type             cw;
   pool_req_type          pool_req;
   logic [WordWidth-1:0]  rd_data;
   logic [WordWidth-1:0]  fresh;
   logic [WordWidth-1:0]  final_word;
   logic [WordWidth:0]    trial;
   logic [WordWidth:0]    diff;

   assign accept       = start & ~busy;
   assign busy         = running_ff | reset;
   assign span_is_zero = (span_ff == '0);
   assign cw           = ucode_rom(pc_ff);

   // sequencer: program counter and jumps
   always_comb begin
      running_in = running_ff;
      pc_in      = pc_ff;
      if (running_ff) begin
         case (cw.seq)
            SEQ_NEXT: pc_in = pc_ff + 1'b1;
            SEQ_SKIP_IF_ZERO: pc_in = span_is_zero ? cw.target : pc_ff + 1'b1;
            SEQ_LOOP: pc_in = (cnt_ff == DivLast) ? pc_ff + 1'b1 : pc_ff;
            SEQ_END: running_in = 1'b0;
            default: running_in = 1'b0;
         endcase
      end else if (accept) begin
         running_in = 1'b1;
         if (req_func == FuncLoad) begin
            pc_in = PcLoad;
         end else if (enable_ff) begin
            pc_in = PcGen;
         end else begin
            pc_in = PcEmitOff;
         end
      end
   end

   // pool port addressing
   always_comb begin
      pool_req = '0;
      if (running_ff) begin
         case (cw.rd_sel)
            RD_I: begin
               pool_req.rd_en   = 1'b1;
               pool_req.rd_addr = idx_ff;
            end
            RD_I13: begin
               pool_req.rd_en   = 1'b1;
               pool_req.rd_addr = idx_ff + TapA;
            end
            RD_I9: begin
               pool_req.rd_en   = 1'b1;
               pool_req.rd_addr = idx_ff + TapB;
            end
            RD_I15: begin
               pool_req.rd_en   = 1'b1;
               pool_req.rd_addr = idx_ff + StepBack;
            end
            default: pool_req.rd_en = 1'b0;
         endcase
         case (cw.op)
            OP_FRESH: begin
               pool_req.wr_en   = 1'b1;
               pool_req.wr_addr = idx_ff;
               pool_req.wr_data = fresh;
            end
            OP_FINAL: begin
               pool_req.wr_en   = 1'b1;
               pool_req.wr_addr = idx_ff;
               pool_req.wr_data = final_word;
            end
            OP_LOAD: begin
               pool_req.wr_en   = 1'b1;
               pool_req.wr_addr = lp_ff;
               pool_req.wr_data = seed_ff;
            end
            default: pool_req.wr_en = 1'b0;
         endcase
      end
   end

   assign fresh      = mix_ff ^ z_ff;
   assign final_word = rd_data ^ mix_ff ^ tmp_ff ^ (rd_data << 2) ^ (mix_ff << 18)
                       ^ (z_ff << 28);
   assign trial      = {rem_ff, dq_ff[WordWidth-1]};
   assign diff       = trial - {1'b0, span_ff};

   // datapath driven by the control word
   always_comb begin
      idx_in        = idx_ff;
      lp_in         = lp_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      mix_in        = mix_ff;
      z_in          = z_ff;
      tmp_in        = tmp_ff;
      word_in       = word_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      out_word_in   = out_word_ff;
      out_ranged_in = out_ranged_ff;
      out_zero_in   = out_zero_ff;
      strobe_in     = 1'b0;
      if (running_ff) begin
         case (cw.op)
            OP_LATCH_X: x_in = rd_data;
            OP_MIX: mix_in = x_ff ^ rd_data ^ (x_ff << 16) ^ (rd_data << 15);
            OP_LATCH_Z: z_in = rd_data ^ (rd_data >> 11);
            OP_FRESH: begin
               tmp_in = fresh ^ ((fresh << 5) & TemperMask);
               idx_in = idx_ff + StepBack;
            end
            OP_FINAL: begin
               word_in = final_word;
               dq_in   = final_word;
               rem_in  = '0;
               cnt_in  = '0;
            end
            OP_DIV_STEP: begin
               // restoring remainder, one dividend bit per step
               rem_in = diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
               dq_in  = dq_ff << 1;
               cnt_in = cnt_ff + 1'b1;
            end
            OP_EMIT_GEN: begin
               out_word_in   = word_ff;
               out_ranged_in = min_ff + (span_is_zero ? word_ff : rem_ff);
               out_zero_in   = span_is_zero;
               strobe_in     = 1'b1;
            end
            OP_EMIT_OFF: begin
               out_word_in   = '0;
               out_ranged_in = min_ff;
               out_zero_in   = 1'b0;
               strobe_in     = 1'b1;
            end
            OP_LOAD: begin
               lp_in  = lp_ff + 1'b1;
               idx_in = '0;
            end
            default: idx_in = idx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         pc_ff      <= PcGen;
         idx_ff     <= '0;
         lp_ff      <= '0;
         enable_ff  <= 1'b1;
         strobe_ff  <= 1'b0;
      end else begin
         running_ff <= running_in;
         pc_ff      <= pc_in;
         idx_ff     <= idx_in;
         lp_ff      <= lp_in;
         strobe_ff  <= strobe_in;
         if (csr_we) begin
            enable_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seed_ff <= req_seed_word;
         min_ff  <= $unsigned(req_range_min);
         span_ff <= $unsigned(req_range_max) - $unsigned(req_range_min) + 32'd1;
      end
      cnt_ff        <= cnt_in;
      x_ff          <= x_in;
      mix_ff        <= mix_in;
      z_ff          <= z_in;
      tmp_ff        <= tmp_in;
      word_ff       <= word_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      out_word_ff   <= out_word_in;
      out_ranged_ff <= out_ranged_in;
      out_zero_ff   <= out_zero_in;
   end

   wb512_pool u_pool (
      .clock   (clock),
      .reset   (reset),
      .req     (pool_req),
      .rd_data (rd_data)
   );

   assign rsp_strobe       = strobe_ff;
   assign rsp_random_word  = out_word_ff;
   assign rsp_ranged_value = $signed(out_ranged_ff);
   assign rsp_span_zero    = out_zero_ff;

   // a result beat only ever follows a busy cycle
   a_strobe_after_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(running_ff))
      else $error("result beat without a running program");

   // an accepted item starts the sequencer
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> running_ff)
      else $error("accepted item did not start the program");

   // the partial remainder stays below the span in the loop
   a_rem_bounded: assert property (@(posedge clock) disable iff (reset)
      (running_ff && cw.op == OP_DIV_STEP) |-> (rem_ff < span_ff))
      else $error("remainder reached the span");

   // the program counter never leaves the program
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (pc_ff <= PcLast))
      else $error("program counter out of range");

   // the remainder loop is never entered with a zero span
   a_no_zero_divide: assert property (@(posedge clock) disable iff (reset)
      (running_ff && cw.op == OP_DIV_STEP) |-> !span_is_zero)
      else $error("remainder loop entered with zero span");

endmodule

@@ hw/rtl/wb512_pool.sv @@
// sixteen-word generator pool with per-entry valid bits and registered read
module wb512_pool import wb512_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  pool_req_type         req,
   output logic [WordWidth-1:0] rd_data
);

   localparam int unsigned Depth = 2 ** IndexWidth;

   logic [WordWidth-1:0] mem [Depth];
   logic [Depth-1:0]     valid_ff;
   logic [Depth-1:0]     valid_in;
   logic [WordWidth-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (req.rd_en) begin
            rd_valid_ff <= valid_ff[req.rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   // an entry never written since reset reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ tb/well512_draw_checker.sv @@
// checker for the well512 generator: predicts every draw and compares each result beat
module well512_draw_checker import wb512_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_func,
   input  logic [31:0]        req_seed_word,
   input  logic signed [31:0] req_range_min,
   input  logic signed [31:0] req_range_max,
   input  logic               csr_we,
   input  logic               csr_wdata,
   input  logic               rsp_strobe,
   input  logic [31:0]        rsp_random_word,
   input  logic signed [31:0] rsp_ranged_value,
   input  logic               rsp_span_zero,
   input  logic               end_of_test,
   output int                 mismatch_count,
   output int                 draws_pending,
   output int                 draws_checked,
   output int                 spans_wrapped
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic [WordWidth-1:0] ranged;
      logic                 span_zero;
   } draw_type;

   logic [WordWidth-1:0]  seed_pool [16];
   logic [IndexWidth-1:0] draw_index;
   logic [IndexWidth-1:0] seed_ptr;
   logic                  draws_enabled;
   draw_type              expected_draws [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // one pool step; updates the pool and the running index, returns the new word
   function automatic logic [WordWidth-1:0] well_step();
      logic [IndexWidth-1:0] i, ia, ib;
      logic [WordWidth-1:0]  x, y, z, mix, fresh, tmp;
      i     = draw_index;
      ia    = i + TapA;
      ib    = i + TapB;
      x     = seed_pool[i];
      y     = seed_pool[ia];
      mix   = x ^ y ^ (x << 16) ^ (y << 15);
      z     = seed_pool[ib];
      z     = z ^ (z >> 11);
      fresh = mix ^ z;
      seed_pool[i] = fresh;
      tmp   = fresh ^ ((fresh << 5) & TemperMask);
      i     = i + StepBack;
      draw_index = i;
      x     = seed_pool[i];
      seed_pool[i] = x ^ mix ^ tmp ^ (x << 2) ^ (mix << 18) ^ (z << 28);
      return seed_pool[i];
   endfunction

   always @(posedge clock) begin : watch
      draw_type             want;
      logic [WordWidth-1:0] word, span, lo_u, hi_u;
      if (reset) begin
         foreach (seed_pool[k]) seed_pool[k] = '0;
         draw_index     = '0;
         seed_ptr       = '0;
         draws_enabled  = 1'b1;
         expected_draws.delete();
         mismatch_count = 0;
         draws_checked  = 0;
         spans_wrapped  = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_draws.size() == 0) begin
               report_mismatch("result beat with no draw pending", rsp_random_word, '0);
            end else begin
               want = expected_draws.pop_front();
               if (rsp_random_word !== want.word)
                  report_mismatch("random_word", rsp_random_word, want.word);
               if (rsp_ranged_value !== want.ranged)
                  report_mismatch("ranged_value", rsp_ranged_value, want.ranged);
               if (rsp_span_zero !== want.span_zero)
                  report_mismatch("span_zero", {31'd0, rsp_span_zero},
                                  {31'd0, want.span_zero});
               draws_checked++;
            end
         end
         if (csr_we)
            draws_enabled = csr_wdata;
         if (start && !busy) begin
            lo_u = req_range_min;
            hi_u = req_range_max;
            if (req_func == FuncLoad) begin
               seed_pool[seed_ptr] = req_seed_word;
               seed_ptr   = seed_ptr + 1'b1;
               draw_index = '0;
            end else if (!draws_enabled) begin
               // disabled: pool untouched, range minimum comes back
               want = '{word: '0, ranged: lo_u, span_zero: 1'b0};
               expected_draws.push_back(want);
            end else begin
               word = well_step();
               span = hi_u - lo_u + 32'd1;
               if (span == '0) begin
                  want = '{word: word, ranged: lo_u + word, span_zero: 1'b1};
                  spans_wrapped++;
               end else begin
                  want = '{word: word, ranged: lo_u + (word % span), span_zero: 1'b0};
               end
               expected_draws.push_back(want);
            end
         end
         if (end_of_test) begin
            while (expected_draws.size() != 0) begin
               want = expected_draws.pop_front();
               report_mismatch("missing result beat", '0, want.word);
            end
         end
      end
      draws_pending = expected_draws.size();
   end

endmodule

@@ tb/well512_random_generator_tb.sv @@
// testbench top for the well512 generator: stimulus phases, csr writes and verdict
module well512_random_generator_tb import wb512_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DrainCycles = 45;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_func = FuncLoad;
   logic [31:0]        req_seed_word = '0;
   logic signed [31:0] req_range_min = '0;
   logic signed [31:0] req_range_max = '0;
   logic               csr_we = 1'b0;
   logic               csr_wdata = 1'b0;
   logic               rsp_strobe;
   logic [31:0]        rsp_random_word;
   logic signed [31:0] rsp_ranged_value;
   logic               rsp_span_zero;
   logic               end_of_test = 1'b0;

   int mismatch_count, draws_pending, draws_checked, spans_wrapped;
   int idle_pct;
   int items_sent = 0;
   int loads_sent = 0;
   int phases_run = 0;

   well512_random_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_seed_word    (req_seed_word),
      .req_range_min    (req_range_min),
      .req_range_max    (req_range_max),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_random_word  (rsp_random_word),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_span_zero    (rsp_span_zero)
   );

   well512_draw_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_seed_word    (req_seed_word),
      .req_range_min    (req_range_min),
      .req_range_max    (req_range_max),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_strobe       (rsp_strobe),
      .rsp_random_word  (rsp_random_word),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_span_zero    (rsp_span_zero),
      .end_of_test      (end_of_test),
      .mismatch_count   (mismatch_count),
      .draws_pending    (draws_pending),
      .draws_checked    (draws_checked),
      .spans_wrapped    (spans_wrapped)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout with %0d draws still pending", draws_pending);
      $display("FAILURE");
      $finish;
   end

   // holds start until the beat is taken; idle cycles carry junk on the fields
   task automatic send_item(input logic func, input logic [31:0] seed,
                            input logic [31:0] lo, input logic [31:0] hi);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start         <= 1'b0;
         req_func      <= 1'($urandom_range(0, 1));
         req_seed_word <= $urandom;
         req_range_min <= $urandom;
         req_range_max <= $urandom;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_func      <= func;
      req_seed_word <= seed;
      req_range_min <= lo;
      req_range_max <= hi;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (func == FuncLoad) loads_sent++;
   endtask

   task automatic pick_range(output logic [31:0] lo, output logic [31:0] hi);
      logic [31:0] edges [4];
      edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      lo = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: hi = lo + $urandom_range(0, 1000);
         4, 5:       hi = $urandom;
         6:          hi = lo - 32'd1;                     // full range, span wraps
         7:          hi = lo;
         8:          hi = lo - $urandom_range(2, 100000); // reversed range
         default: begin
            lo = edges[2'($urandom_range(0, 3))];
            hi = edges[2'($urandom_range(0, 3))];
         end
      endcase
   endtask

   task automatic pick_seed(output logic [31:0] seed);
      case ($urandom_range(0, 9))
         0:       seed = '0;
         1:       seed = '1;
         default: seed = $urandom;
      endcase
   endtask

   // mostly draws, with single reseeds and the odd burst of up to 20 reseeds
   task automatic send_random(input int count);
      logic [31:0] seed, lo, hi;
      int          sent, burst;
      sent = 0;
      while (sent < count) begin
         pick_range(lo, hi);
         case ($urandom_range(0, 99)) inside
            [0:2]: begin
               burst = $urandom_range(1, 20);
               repeat (burst) begin
                  pick_seed(seed);
                  send_item(FuncLoad, seed, lo, hi);
               end
               sent += burst;
            end
            [3:11]: begin
               pick_seed(seed);
               send_item(FuncLoad, seed, lo, hi);
               sent++;
            end
            default: begin
               send_item(FuncGenerate, $urandom, lo, hi);
               sent++;
            end
         endcase
      end
   endtask

   // let the block go quiet: no draw pending and any load finished
   task automatic drain();
      int guard;
      guard = 0;
      @(negedge clock);
      start <= 1'b0;
      while (draws_pending != 0 && guard < 1000) begin
         @(negedge clock);
         guard++;
      end
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      phases_run++;
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: unseeded pool, wrapping seed pointer, range corners
      idle_pct = 0;
      send_item(FuncGenerate, '0, 32'd0, 32'd9);
      send_item(FuncGenerate, '0, 32'h8000_0000, 32'h7FFF_FFFF);
      for (int k = 0; k < 17; k++) begin
         case (k)
            0:       send_item(FuncLoad, 32'hFFFF_FFFF, $urandom, $urandom);
            1:       send_item(FuncLoad, 32'h0000_0000, $urandom, $urandom);
            2:       send_item(FuncLoad, 32'hAAAA_AAAA, $urandom, $urandom);
            3:       send_item(FuncLoad, 32'h5555_5555, $urandom, $urandom);
            default: send_item(FuncLoad, 32'h9E37_79B9 * k, $urandom, $urandom);
         endcase
      end
      send_item(FuncGenerate, '0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(FuncGenerate, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(FuncGenerate, '0, 32'd100, -32'sd100);
      send_item(FuncGenerate, '0, 32'd0, 32'hFFFF_FFFE);
      send_item(FuncGenerate, '0, 32'h8000_0000, 32'h8000_0000);
      send_item(FuncGenerate, '0, -32'sd5, 32'd5);

      write_enable(1'b1);
      send_random(350);

      // generator off: draws return the minimum, loads still reseed
      write_enable(1'b0);
      idle_pct = 19;
      send_item(FuncGenerate, '1, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(FuncGenerate, '1, 32'd100, -32'sd100);
      send_item(FuncLoad, 32'h1234_5678, '0, '0);
      send_item(FuncGenerate, '0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_random(150);

      write_enable(1'b1);
      idle_pct = 85;
      send_random(400);

      write_enable(1'b1);
      idle_pct = 19;
      send_random(350);

      drain();
      end_of_test <= 1'b1;
      @(negedge clock);
      end_of_test <= 1'b0;
      @(negedge clock);

      $display("covered %0d items (%0d seed loads) over %0d csr settings and three idle rates",
               items_sent, loads_sent, phases_run + 1);
      $display("checked %0d result beats, %0d of them with a wrapped span",
               draws_checked, spans_wrapped);
      if (mismatch_count == 0 && draws_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
